// ===== design/matrix3_inverse_defines.svh =====
// Assertion macros for the 3x3 inverse block.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define M3I_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3i: assertion failed");
`define M3I_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3i: assertion failed");
`else
`define M3I_ASSERT_SAME(label, ante, cons)
`define M3I_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/m3i_pkg.sv =====
package m3i_pkg;

  localparam int N_ELEM = 9;
  localparam int N_ROW = 3;

  localparam int TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_TOL = 1'b0;

  // Element order: c0r0 c0r1 c0r2 c1r0 c1r1 c1r2 c2r0 c2r1 c2r2.
  // Cofactor k is elem[P]*elem[Q] - elem[S]*elem[T], in output order.
  localparam int COF_P [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int COF_Q [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int COF_S [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int COF_T [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // First row of the matrix, used for the determinant expansion.
  localparam int ROW0 [N_ROW] = '{0, 3, 6};

endpackage

// ===== design/matrix3_inverse.sv =====
// An accepted item passes through the seven arithmetic stages and then the bit-per-stage
// quotient pipeline, and its result is registered at the output.
// Throughput: one item per cycle; a stalled result holds the whole pipeline in place.
// Reset clears all valid bits and sets the singular tolerance to 1.
`include "matrix3_inverse_defines.svh"

module matrix3_inverse #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [m3i_pkg::ADDR_W-1:0]          paddr,
  input  logic [m3i_pkg::DATA_W-1:0]          pwdata,
  output logic [m3i_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c0r0,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c0r1,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c0r2,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c1r0,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c1r1,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c1r2,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c2r0,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c2r1,
  input  logic signed [ELEM_WIDTH-1:0]        in_src_c2r2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c0r0,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c0r1,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c0r2,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c1r0,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c1r1,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c1r2,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c2r0,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c2r1,
  output logic signed [ELEM_WIDTH-1:0]        out_inv_c2r2,
  output logic                                out_singular,
  output logic signed [ELEM_WIDTH-1:0]        out_det_value
);

  localparam int E = ELEM_WIDTH;
  localparam int NE = m3i_pkg::N_ELEM;
  localparam int NR = m3i_pkg::N_ROW;
  localparam int PW = 2 * E;
  localparam int CS = 2 * E + 1;
  localparam int CW = 2 * E;
  localparam int DW = 3 * E;
  localparam int DS = 3 * E + 1;
  localparam int NW = 2 * E + 2 * FRAC_BITS;
  localparam int TW = (DW > m3i_pkg::TOL_W + 2 * FRAC_BITS) ? DW
                                                            : m3i_pkg::TOL_W + 2 * FRAC_BITS;
  localparam int NST = E + 8;
  localparam logic [E-1:0] SMAX = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] SMIN = {1'b1, {(E-1){1'b0}}};

  logic [m3i_pkg::TOL_W-1:0] tol_r;
  logic                      reg_hit_w;

  logic                      en;
  logic [NST-1:0]            v_r;
  logic                      out_valid_r;

  logic signed [E-1:0]  src_w   [NE];
  logic signed [PW-1:0] pp1_r   [NE];
  logic signed [PW-1:0] ps1_r   [NE];
  logic signed [E-1:0]  row1_r  [NR];
  logic signed [CS-1:0] cof2_r  [NE];
  logic signed [E-1:0]  row2_r  [NR];
  logic [CW-1:0]        cm3_r   [NE];
  logic                 cn3_r   [NE];
  logic [E-1:0]         am3_r   [NR];
  logic                 an3_r   [NR];
  logic [PW-1:0]        plo4_r  [NR];
  logic [PW-1:0]        phi4_r  [NR];
  logic                 tn4_r   [NR];
  logic [CW-1:0]        cm4_r   [NE];
  logic                 cn4_r   [NE];
  logic [DW-1:0]        tm_w    [NR];
  logic signed [DS-1:0] ts_w    [NR];
  logic signed [DS-1:0] det5_nxt;
  logic signed [DS-1:0] det5_r;
  logic [CW-1:0]        cm5_r   [NE];
  logic                 cn5_r   [NE];
  logic [DW-1:0]        dm6_r;
  logic                 dn6_r;
  logic [CW-1:0]        cm6_r   [NE];
  logic                 cn6_r   [NE];
  logic [DW-1:0]        sh6_w;
  logic                 sing7_nxt;
  logic [E-1:0]         dv7_nxt;
  logic                 sing7_r;
  logic [E-1:0]         dv7_r;
  logic [NW-1:0]        num7_r  [NE];
  logic                 qn7_r   [NE];
  logic [DW-1:0]        den7_r;
  logic                 sd_r    [E+1];
  logic [E-1:0]         dvd_r   [E+1];
  logic signed [E-1:0]  quo_w   [NE];
  logic signed [E-1:0]  inv_r   [NE];
  logic                 sing_o_r;
  logic signed [E-1:0]  det_o_r;
  logic                 inv_any_w;

  assign reg_hit_w = paddr[m3i_pkg::ADDR_W-1:2] == m3i_pkg::REG_TOL;
  assign pready = 1'b1;
  assign prdata = reg_hit_w ? m3i_pkg::DATA_W'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= m3i_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit_w) begin
      tol_r <= pwdata[m3i_pkg::TOL_W-1:0];
    end
  end

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
      out_valid_r <= v_r[NST-1];
    end
  end

  assign src_w[0] = in_src_c0r0;
  assign src_w[1] = in_src_c0r1;
  assign src_w[2] = in_src_c0r2;
  assign src_w[3] = in_src_c1r0;
  assign src_w[4] = in_src_c1r1;
  assign src_w[5] = in_src_c1r2;
  assign src_w[6] = in_src_c2r0;
  assign src_w[7] = in_src_c2r1;
  assign src_w[8] = in_src_c2r2;

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      tm_w[r] = (DW'(phi4_r[r]) << E) + DW'(plo4_r[r]);
      ts_w[r] = tn4_r[r] ? -$signed(DS'(tm_w[r])) : $signed(DS'(tm_w[r]));
    end
    det5_nxt = ts_w[0] + ts_w[1] + ts_w[2];
  end

  always_comb begin
    sh6_w = dm6_r >> (2 * FRAC_BITS);
    sing7_nxt = (dm6_r == '0) || (TW'(dm6_r) < (TW'(tol_r) << (2 * FRAC_BITS)));
    if (!dn6_r) begin
      dv7_nxt = (sh6_w > DW'(SMAX)) ? SMAX : E'(sh6_w);
    end else begin
      dv7_nxt = (sh6_w > DW'(SMIN)) ? SMIN : -E'(sh6_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        pp1_r[k] <= PW'(src_w[m3i_pkg::COF_P[k]]) * PW'(src_w[m3i_pkg::COF_Q[k]]);
        ps1_r[k] <= PW'(src_w[m3i_pkg::COF_S[k]]) * PW'(src_w[m3i_pkg::COF_T[k]]);
        cof2_r[k] <= CS'(pp1_r[k]) - CS'(ps1_r[k]);
        cm3_r[k] <= cof2_r[k][CS-1] ? CW'(-cof2_r[k]) : CW'(cof2_r[k]);
        cn3_r[k] <= cof2_r[k][CS-1];
        cm4_r[k] <= cm3_r[k];
        cn4_r[k] <= cn3_r[k];
        cm5_r[k] <= cm4_r[k];
        cn5_r[k] <= cn4_r[k];
        cm6_r[k] <= cm5_r[k];
        cn6_r[k] <= cn5_r[k];
        num7_r[k] <= NW'(cm6_r[k]) << (2 * FRAC_BITS);
        qn7_r[k] <= cn6_r[k] ^ dn6_r;
      end
      for (int r = 0; r < NR; r++) begin
        row1_r[r] <= src_w[m3i_pkg::ROW0[r]];
        row2_r[r] <= row1_r[r];
        am3_r[r] <= row2_r[r][E-1] ? E'(-row2_r[r]) : E'(row2_r[r]);
        an3_r[r] <= row2_r[r][E-1];
        plo4_r[r] <= PW'(am3_r[r]) * PW'(cm3_r[r][E-1:0]);
        phi4_r[r] <= PW'(am3_r[r]) * PW'(cm3_r[r][CW-1:E]);
        tn4_r[r] <= an3_r[r] ^ cn3_r[r];
      end
      det5_r <= det5_nxt;
      dm6_r <= det5_r[DS-1] ? DW'(-det5_r) : DW'(det5_r);
      dn6_r <= det5_r[DS-1];
      sing7_r <= sing7_nxt;
      dv7_r <= dv7_nxt;
      den7_r <= dm6_r;
      sd_r[0] <= sing7_r;
      dvd_r[0] <= dv7_r;
      for (int s = 1; s <= E; s++) begin
        sd_r[s] <= sd_r[s-1];
        dvd_r[s] <= dvd_r[s-1];
      end
      for (int k = 0; k < NE; k++) begin
        inv_r[k] <= sd_r[E] ? '0 : quo_w[k];
      end
      sing_o_r <= sd_r[E];
      det_o_r <= $signed(dvd_r[E]);
    end
  end

  m3i_div #(
    .ELEM_WIDTH(E),
    .NUM_WIDTH (NW),
    .DEN_WIDTH (DW)
  ) u_div (
    .clk  (clk),
    .en   (en),
    .num_i(num7_r),
    .neg_i(qn7_r),
    .den_i(den7_r),
    .quo_o(quo_w)
  );

  assign out_valid = out_valid_r;
  assign out_inv_c0r0 = inv_r[0];
  assign out_inv_c0r1 = inv_r[1];
  assign out_inv_c0r2 = inv_r[2];
  assign out_inv_c1r0 = inv_r[3];
  assign out_inv_c1r1 = inv_r[4];
  assign out_inv_c1r2 = inv_r[5];
  assign out_inv_c2r0 = inv_r[6];
  assign out_inv_c2r1 = inv_r[7];
  assign out_inv_c2r2 = inv_r[8];
  assign out_singular = sing_o_r;
  assign out_det_value = det_o_r;

  always_comb begin
    inv_any_w = 1'b0;
    for (int k = 0; k < NE; k++) begin
      inv_any_w = inv_any_w || (inv_r[k] != '0);
    end
  end

  `M3I_ASSERT_SAME(a_sing_zero, out_valid_r && sing_o_r, !inv_any_w)
  `M3I_ASSERT_NEXT(a_stall_hold, !en, $stable(v_r) && $stable(sing_o_r))
  `M3I_ASSERT_NEXT(a_tol_write, psel && penable && pwrite && reg_hit_w, tol_r == $past(pwdata[m3i_pkg::TOL_W-1:0]))

endmodule

// ===== design/m3i_div.sv =====
module m3i_div #(
  parameter int ELEM_WIDTH = 32,
  parameter int NUM_WIDTH = 96,
  parameter int DEN_WIDTH = 96
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_WIDTH-1:0]         num_i [m3i_pkg::N_ELEM],
  input  logic                         neg_i [m3i_pkg::N_ELEM],
  input  logic [DEN_WIDTH-1:0]         den_i,
  output logic signed [ELEM_WIDTH-1:0] quo_o [m3i_pkg::N_ELEM]
);

  localparam int RW = (NUM_WIDTH > DEN_WIDTH + ELEM_WIDTH) ? NUM_WIDTH
                                                          : DEN_WIDTH + ELEM_WIDTH;
  localparam int NL = m3i_pkg::N_ELEM;
  localparam int NS = ELEM_WIDTH + 1;
  localparam logic [ELEM_WIDTH-1:0] SMAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] SMIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic [RW-1:0]         rem_r   [NS][NL];
  logic [ELEM_WIDTH-1:0] quo_r   [NS][NL];
  logic                  ovf_r   [NS][NL];
  logic                  neg_r   [NS][NL];
  logic [DEN_WIDTH-1:0]  den_r   [NS];
  logic [RW-1:0]         trial_w [NS];
  logic                  ge_w    [NS][NL];

  always_comb begin
    trial_w[0] = RW'(den_r[0]) << ELEM_WIDTH;
    for (int l = 0; l < NL; l++) begin
      ge_w[0][l] = 1'b0;
    end
    for (int s = 1; s < NS; s++) begin
      trial_w[s] = RW'(den_r[s-1]) << (ELEM_WIDTH - s);
      for (int l = 0; l < NL; l++) begin
        ge_w[s][l] = rem_r[s-1][l] >= trial_w[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_i;
      for (int l = 0; l < NL; l++) begin
        rem_r[0][l] <= RW'(num_i[l]);
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= RW'(num_i[l]) >= (RW'(den_i) << ELEM_WIDTH);
        neg_r[0][l] <= neg_i[l];
      end
      for (int s = 1; s < NS; s++) begin
        den_r[s] <= den_r[s-1];
        for (int l = 0; l < NL; l++) begin
          ovf_r[s][l] <= ovf_r[s-1][l];
          neg_r[s][l] <= neg_r[s-1][l];
          if (ge_w[s][l]) begin
            rem_r[s][l] <= rem_r[s-1][l] - trial_w[s];
            quo_r[s][l] <= quo_r[s-1][l] | (ELEM_WIDTH'(1) << (ELEM_WIDTH - s));
          end else begin
            rem_r[s][l] <= rem_r[s-1][l];
            quo_r[s][l] <= quo_r[s-1][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (!neg_r[NS-1][l]) begin
        quo_o[l] = (ovf_r[NS-1][l] || quo_r[NS-1][l] > SMAX) ? $signed(SMAX)
                                                             : $signed(quo_r[NS-1][l]);
      end else begin
        quo_o[l] = (ovf_r[NS-1][l] || quo_r[NS-1][l] > SMIN) ? $signed(SMIN)
                                                             : $signed(-quo_r[NS-1][l]);
      end
    end
  end

endmodule
